[design/sign_magnitude_integer_alu_core_macros.svh]
// assertion macros for the sign-magnitude alu core
// used by design/sign_magnitude_integer_alu_core.sv, expects clk and rst in scope
`ifndef SIGN_MAGNITUDE_INTEGER_ALU_CORE_MACROS_SVH
`define SIGN_MAGNITUDE_INTEGER_ALU_CORE_MACROS_SVH

// implication in the same cycle
`define SMI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication a fixed number of cycles later
`define SMI_ASSERT_LATER(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[design/smi_pkg.sv]
// shared types, codes and constants for the sign-magnitude alu core
// no dependencies
package smi_pkg;

  localparam int MAG_BYTES = 8;
  localparam int MAG_W = 8 * MAG_BYTES;
  localparam logic [63:0] MAG_MASK = {64{1'b1}} >> (64 - MAG_W);
  localparam logic [7:0] SHIFT_LIM = 8'(MAG_W);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_CMP = 3'd3,
    OP_SHL = 3'd4,
    OP_SHR = 3'd5
  } op_t;

  localparam logic [1:0] SG_ZERO = 2'd0;
  localparam logic [1:0] SG_POS = 2'd1;
  localparam logic [1:0] SG_NEG = 2'd2;
  localparam logic [1:0] SG_ODD = 2'd3;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // first stage results, multiply still in partial products
  typedef struct packed {
    logic        is_mul;
    logic [63:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic [1:0]  sign;
    logic [63:0] mag;
    logic [1:0]  cmp;
  } s1_t;

  function automatic logic [1:0] norm_sign(input logic [1:0] s);
    return (s == SG_ODD) ? SG_POS : s;
  endfunction

endpackage

[design/smi_exec.sv]
// first stage: add, sub, compare, shifts and multiply partial products
// depends on smi_pkg
module smi_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       op,
  input  logic [1:0]       a_sign,
  input  logic [63:0]      a_mag,
  input  logic [1:0]       b_sign,
  input  logic [63:0]      b_mag,
  output logic             out_valid,
  output smi_pkg::s1_t     out_data
);

  logic         out_valid_next;
  smi_pkg::s1_t res;

  always_comb begin
    logic [1:0]  as;
    logic [1:0]  bs;
    logic [63:0] am;
    logic [63:0] bm;
    logic        an;
    logic        bn;
    logic [64:0] d_ab;
    logic [63:0] d_ba;
    logic        a_lt_b;
    logic        a_eq_b;
    logic [63:0] sum;
    logic [7:0]  cnt;

    as = smi_pkg::norm_sign(a_sign);
    bs = smi_pkg::norm_sign(b_sign);
    am = a_mag & smi_pkg::MAG_MASK;
    bm = b_mag & smi_pkg::MAG_MASK;
    an = (as == smi_pkg::SG_NEG);
    bn = (bs == smi_pkg::SG_NEG);
    d_ab = {1'b0, am} - {1'b0, bm};
    d_ba = bm - am;
    a_lt_b = d_ab[64];
    a_eq_b = (am == bm);
    sum = am + bm;
    cnt = bm[7:0];

    res.is_mul = 1'b0;
    // 32 by 32 product, full 64-bit result
    res.pp_ll = {32'b0, am[31:0]} * {32'b0, bm[31:0]};
    res.pp_lh = am[31:0] * bm[63:32];
    res.pp_hl = am[63:32] * bm[31:0];
    res.sign = smi_pkg::SG_ZERO;
    res.mag = '0;
    res.cmp = smi_pkg::CMP_EQ;

    unique case (op) inside
      smi_pkg::OP_ADD, smi_pkg::OP_SUB: begin
        if (op == smi_pkg::OP_SUB) begin
          bn = !bn;
        end
        if (an == bn) begin
          res.mag = sum & smi_pkg::MAG_MASK;
          res.sign = an ? smi_pkg::SG_NEG : smi_pkg::SG_POS;
        end else begin
          res.mag = a_lt_b ? d_ba : d_ab[63:0];
          // larger magnitude decides; equal gives zero magnitude
          res.sign = (an ? a_lt_b : !a_lt_b) ? smi_pkg::SG_POS : smi_pkg::SG_NEG;
        end
      end
      smi_pkg::OP_MUL: begin
        if (as != smi_pkg::SG_ZERO && bs != smi_pkg::SG_ZERO) begin
          res.is_mul = 1'b1;
          res.sign = (as == bs) ? smi_pkg::SG_POS : smi_pkg::SG_NEG;
        end
      end
      smi_pkg::OP_CMP: begin
        if (as != bs) begin
          if (as == smi_pkg::SG_POS) begin
            res.cmp = smi_pkg::CMP_GT;
          end else if (bs == smi_pkg::SG_POS) begin
            res.cmp = smi_pkg::CMP_LT;
          end else if (as == smi_pkg::SG_ZERO) begin
            res.cmp = smi_pkg::CMP_GT;
          end else begin
            res.cmp = smi_pkg::CMP_LT;
          end
        end else if (as == smi_pkg::SG_ZERO || a_eq_b) begin
          res.cmp = smi_pkg::CMP_EQ;
        end else if (a_lt_b == (as == smi_pkg::SG_POS)) begin
          res.cmp = smi_pkg::CMP_LT;
        end else begin
          res.cmp = smi_pkg::CMP_GT;
        end
      end
      smi_pkg::OP_SHL, smi_pkg::OP_SHR: begin
        if (cnt < smi_pkg::SHIFT_LIM) begin
          res.mag = ((op == smi_pkg::OP_SHL) ? (am << cnt) : (am >> cnt))
                    & smi_pkg::MAG_MASK;
        end
        res.sign = as;
      end
      default: begin
        res.sign = smi_pkg::SG_ZERO;
      end
    endcase
  end

  assign out_valid_next = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= res;
  end

endmodule

[design/smi_final.sv]
// second stage: multiply partial product sum, zero-sign rule, result register
// depends on smi_pkg
module smi_final (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  smi_pkg::s1_t     in_data,
  output logic             done,
  output logic [1:0]       r_sign,
  output logic [63:0]      r_mag,
  output logic [1:0]       cmp_result
);

  logic [31:0] cross_sum;
  logic [63:0] prod;
  logic [63:0] mag_next;
  logic [1:0]  sign_next;

  assign cross_sum = in_data.pp_lh + in_data.pp_hl;
  assign prod = (in_data.pp_ll + {cross_sum, 32'b0}) & smi_pkg::MAG_MASK;
  assign mag_next = in_data.is_mul ? prod : in_data.mag;
  assign sign_next = (mag_next == '0) ? smi_pkg::SG_ZERO : in_data.sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_sign <= sign_next;
    r_mag <= mag_next;
    cmp_result <= in_data.cmp;
  end

endmodule

[design/sign_magnitude_integer_alu_core.sv]
// top level of the sign-magnitude integer alu: input register and two stages
// depends on smi_pkg, smi_exec, smi_final and sign_magnitude_integer_alu_core_macros.svh
//
// One request is taken in every clock cycle: busy stays low, so start alone marks a transfer.
// Each request gives exactly one result, shown for one cycle with done high: the request
// passes the input register, the first stage and the result register before done rises.
// The 64-bit multiply is split into 32-bit partial products in the first stage and summed
// in the second. Results come out in request order and cannot be held off: the receiver
// must take each one in the cycle it is shown.
`include "sign_magnitude_integer_alu_core_macros.svh"

module sign_magnitude_integer_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [1:0]  a_sign,
  input  logic [63:0] a_mag,
  input  logic [1:0]  b_sign,
  input  logic [63:0] b_mag,
  output logic        done,
  output logic [1:0]  r_sign,
  output logic [63:0] r_mag,
  output logic [1:0]  cmp_result
);

  logic         in_valid;
  logic [2:0]   in_op;
  logic [1:0]   in_a_sign;
  logic [63:0]  in_a_mag;
  logic [1:0]   in_b_sign;
  logic [63:0]  in_b_mag;
  logic         s1_valid;
  smi_pkg::s1_t s1_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_op <= op;
    in_a_sign <= a_sign;
    in_a_mag <= a_mag;
    in_b_sign <= b_sign;
    in_b_mag <= b_mag;
  end

  smi_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (in_op),
    .a_sign    (in_a_sign),
    .a_mag     (in_a_mag),
    .b_sign    (in_b_sign),
    .b_mag     (in_b_mag),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  smi_final u_final (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_data    (s1_data),
    .done       (done),
    .r_sign     (r_sign),
    .r_mag      (r_mag),
    .cmp_result (cmp_result)
  );

  `SMI_ASSERT_LATER(a_latency, start && !busy, 3, done, "transfer without result")
  `SMI_ASSERT_NOW(a_zero_sign, done && r_mag == '0, r_sign == smi_pkg::SG_ZERO, "signed zero")
  `SMI_ASSERT_NOW(a_cmp_clean, done && cmp_result != smi_pkg::CMP_EQ, r_mag == '0, "cmp mag set")

endmodule

[tb/alu_result_checker.sv]
`timescale 1ns / 100ps
// result checker for the sign-magnitude alu core: works out each result from the
// accepted request and compares it field by field with what the core returns; uses smi_pkg
module alu_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  op,
  input  logic [1:0]  a_sign,
  input  logic [63:0] a_mag,
  input  logic [1:0]  b_sign,
  input  logic [63:0] b_mag,
  input  logic        done,
  input  logic [1:0]  r_sign,
  input  logic [63:0] r_mag,
  input  logic [1:0]  cmp_result,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);

  typedef struct packed {
    logic [1:0]  sign;
    logic [63:0] mag;
    logic [1:0]  cmp;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t sm_alu_result(input logic [2:0] code,
                                                input logic [1:0] sa_in,
                                                input logic [63:0] ma_in,
                                                input logic [1:0] sb_in,
                                                input logic [63:0] mb_in);
    alu_result_t res;
    logic [1:0]  sa;
    logic [1:0]  sb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        a_neg;
    logic        b_neg;
    logic [7:0]  cnt;
    sa = (sa_in == smi_pkg::SG_ODD) ? smi_pkg::SG_POS : sa_in;
    sb = (sb_in == smi_pkg::SG_ODD) ? smi_pkg::SG_POS : sb_in;
    ma = ma_in & smi_pkg::MAG_MASK;
    mb = mb_in & smi_pkg::MAG_MASK;
    a_neg = (sa == smi_pkg::SG_NEG);
    b_neg = (sb == smi_pkg::SG_NEG);
    res.sign = smi_pkg::SG_ZERO;
    res.mag = '0;
    res.cmp = smi_pkg::CMP_EQ;
    case (code) inside
      smi_pkg::OP_ADD, smi_pkg::OP_SUB: begin
        if (code == smi_pkg::OP_SUB) b_neg = !b_neg;
        if (a_neg == b_neg) begin
          res.mag = (ma + mb) & smi_pkg::MAG_MASK;
          res.sign = a_neg ? smi_pkg::SG_NEG : smi_pkg::SG_POS;
        end else begin
          // positive operand minus negative one's magnitude
          hi = a_neg ? mb : ma;
          lo = a_neg ? ma : mb;
          if (hi > lo) begin
            res.sign = smi_pkg::SG_POS;
            res.mag = hi - lo;
          end else if (hi < lo) begin
            res.sign = smi_pkg::SG_NEG;
            res.mag = lo - hi;
          end
        end
      end
      smi_pkg::OP_MUL: begin
        if (sa != smi_pkg::SG_ZERO && sb != smi_pkg::SG_ZERO) begin
          res.mag = (ma * mb) & smi_pkg::MAG_MASK;
          res.sign = (sa == sb) ? smi_pkg::SG_POS : smi_pkg::SG_NEG;
        end
      end
      smi_pkg::OP_CMP: begin
        if (sa != sb) begin
          if (sa == smi_pkg::SG_POS) res.cmp = smi_pkg::CMP_GT;
          else if (sb == smi_pkg::SG_POS) res.cmp = smi_pkg::CMP_LT;
          else if (sa == smi_pkg::SG_ZERO) res.cmp = smi_pkg::CMP_GT;
          else res.cmp = smi_pkg::CMP_LT;
        end else if (sa == smi_pkg::SG_ZERO || ma == mb) begin
          res.cmp = smi_pkg::CMP_EQ;
        end else if ((ma < mb) == (sa == smi_pkg::SG_POS)) begin
          res.cmp = smi_pkg::CMP_LT;
        end else begin
          res.cmp = smi_pkg::CMP_GT;
        end
      end
      smi_pkg::OP_SHL, smi_pkg::OP_SHR: begin
        cnt = mb[7:0];
        if (cnt < smi_pkg::MAG_W)
          res.mag = ((code == smi_pkg::OP_SHL) ? (ma << cnt) : (ma >> cnt))
                    & smi_pkg::MAG_MASK;
        res.sign = sa;
      end
      default: begin
      end
    endcase
    if (res.mag == '0) res.sign = smi_pkg::SG_ZERO;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    alu_result_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      expected_results.delete();
      mismatches <= 0;
      checked <= 0;
      outstanding <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          bad++;
        end else begin
          want = expected_results.pop_front();
          if (r_sign !== want.sign) begin
            $error("r_sign expected %0d got %0d", want.sign, r_sign);
            bad++;
          end
          if (r_mag !== want.mag) begin
            $error("r_mag expected %h got %h", want.mag, r_mag);
            bad++;
          end
          if (cmp_result !== want.cmp) begin
            $error("cmp_result expected %0d got %0d", want.cmp, cmp_result);
            bad++;
          end
          checked <= checked + 1;
        end
      end
      if (start && !busy)
        expected_results.push_back(sm_alu_result(op, a_sign, a_mag, b_sign, b_mag));
      mismatches <= mismatches + bad;
      outstanding <= expected_results.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// top of the sign-magnitude alu testbench: drives directed and random requests
// into the core with random gaps; needs smi_pkg, the core and alu_result_checker
module tb;

  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  op;
  logic [1:0]  a_sign;
  logic [63:0] a_mag;
  logic [1:0]  b_sign;
  logic [63:0] b_mag;
  logic        done;
  logic [1:0]  r_sign;
  logic [63:0] r_mag;
  logic [1:0]  cmp_result;

  int mismatches;
  int outstanding;
  int checked;
  int cycles = 0;
  int requests = 0;
  int directed = 0;
  int per_op[8];
  int burst_left = 0;

  sign_magnitude_integer_alu_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .a_sign(a_sign), .a_mag(a_mag), .b_sign(b_sign), .b_mag(b_mag),
    .done(done), .r_sign(r_sign), .r_mag(r_mag), .cmp_result(cmp_result)
  );

  alu_result_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .a_sign(a_sign), .a_mag(a_mag), .b_sign(b_sign), .b_mag(b_mag),
    .done(done), .r_sign(r_sign), .r_mag(r_mag), .cmp_result(cmp_result),
    .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // one request, held until the core takes it
  task automatic issue(input logic [2:0] code, input logic [1:0] sa, input logic [63:0] ma,
                       input logic [1:0] sb, input logic [63:0] mb);
    @(negedge clk);
    op <= code;
    a_sign <= sa;
    a_mag <= ma;
    b_sign <= sb;
    b_mag <= mb;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    requests++;
    per_op[code]++;
  endtask

  // idle cycles with junk on the request fields
  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      op <= 3'($urandom);
      a_sign <= 2'($urandom);
      a_mag <= {$urandom, $urandom};
      b_sign <= 2'($urandom);
      b_mag <= {$urandom, $urandom};
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_mag();
    case ($urandom_range(0, 9))
      0, 1, 2: return {$urandom, $urandom};
      3: return 64'($urandom_range(0, 15));
      4: return '1 - 64'($urandom_range(0, 15));
      5: return 64'(1) << $urandom_range(0, 63);
      6: return '0;
      7: return 64'($urandom);
      8: return {$urandom, 32'($urandom_range(0, 3))};
      default: return {32'($urandom_range(0, 3)), $urandom};
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return OP_RSV6;
    if (r == 1) return OP_RSV7;
    return 3'((r - 2) % 6);
  endfunction

  task automatic random_request();
    logic [2:0]  code;
    logic [63:0] ma;
    logic [63:0] mb;
    code = pick_op();
    ma = pick_mag();
    mb = pick_mag();
    if (code == smi_pkg::OP_SHL || code == smi_pkg::OP_SHR) begin
      mb = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0, 1, 2, 3: mb[7:0] = 8'($urandom_range(0, 63));
        4: mb[7:0] = 8'($urandom_range(64, 255));
        default: mb[7:0] = 8'($urandom_range(60, 70));
      endcase
    end else if ($urandom_range(0, 4) == 0) begin
      mb = ma;
    end
    issue(code, 2'($urandom), ma, 2'($urandom), mb);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = smi_pkg::OP_ADD;
    a_sign = smi_pkg::SG_ZERO;
    a_mag = '0;
    b_sign = smi_pkg::SG_ZERO;
    b_mag = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    issue(smi_pkg::OP_ADD, smi_pkg::SG_POS, '1, smi_pkg::SG_POS, 64'd1);
    issue(smi_pkg::OP_ADD, smi_pkg::SG_POS, 64'd5, smi_pkg::SG_NEG, 64'd5);
    issue(smi_pkg::OP_ADD, smi_pkg::SG_NEG, 64'd3, smi_pkg::SG_POS, 64'd10);
    issue(smi_pkg::OP_SUB, smi_pkg::SG_NEG, '1, smi_pkg::SG_NEG, 64'd1);
    issue(smi_pkg::OP_SUB, smi_pkg::SG_POS, 64'd1, smi_pkg::SG_POS, '1);
    issue(smi_pkg::OP_SUB, smi_pkg::SG_NEG, '1, smi_pkg::SG_POS, '1);
    issue(smi_pkg::OP_ADD, smi_pkg::SG_ZERO, 64'h1234, smi_pkg::SG_NEG, 64'h10);
    issue(smi_pkg::OP_ADD, smi_pkg::SG_ODD, 64'h8000_0000_0000_0000,
          smi_pkg::SG_ODD, 64'h8000_0000_0000_0000);
    issue(smi_pkg::OP_MUL, smi_pkg::SG_POS, '1, smi_pkg::SG_POS, '1);
    issue(smi_pkg::OP_MUL, smi_pkg::SG_NEG, 64'hFFFF_FFFF_0000_0001,
          smi_pkg::SG_POS, 64'h1_0000_0003);
    issue(smi_pkg::OP_MUL, smi_pkg::SG_ZERO, 64'd7, smi_pkg::SG_NEG, 64'd9);
    issue(smi_pkg::OP_MUL, smi_pkg::SG_NEG, 64'h1000, smi_pkg::SG_ODD, 64'h0010_0000_0000_0000);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_ZERO, 64'd5, smi_pkg::SG_ZERO, 64'd9);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_POS, 64'd0, smi_pkg::SG_ZERO, 64'd0);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_ZERO, 64'd1, smi_pkg::SG_NEG, 64'd1);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_NEG, 64'd2, smi_pkg::SG_POS, 64'd1);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_NEG, 64'd5, smi_pkg::SG_NEG, 64'd9);
    issue(smi_pkg::OP_CMP, smi_pkg::SG_POS, '1, smi_pkg::SG_ODD, '1);
    issue(smi_pkg::OP_SHL, smi_pkg::SG_NEG, '1, smi_pkg::SG_POS, 64'd0);
    issue(smi_pkg::OP_SHL, smi_pkg::SG_POS, 64'd1, smi_pkg::SG_NEG, 64'd63);
    issue(smi_pkg::OP_SHL, smi_pkg::SG_POS, '1, smi_pkg::SG_ZERO, 64'd64);
    issue(smi_pkg::OP_SHR, smi_pkg::SG_NEG, '1, smi_pkg::SG_NEG, 64'hFFFF_FFFF_FFFF_FF3F);
    issue(smi_pkg::OP_SHR, smi_pkg::SG_ZERO, 64'h10, smi_pkg::SG_POS, 64'd1);
    issue(smi_pkg::OP_SHR, smi_pkg::SG_POS, '1, smi_pkg::SG_POS, 64'h100);
    issue(OP_RSV6, smi_pkg::SG_POS, 64'd3, smi_pkg::SG_POS, 64'd4);
    issue(OP_RSV7, smi_pkg::SG_NEG, '1, smi_pkg::SG_NEG, '1);
    directed = requests;

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) drain();
      random_request();
      pause(pick_gap());
    end

    drain();
    repeat (10) @(negedge clk);
    $display("%0d requests (%0d directed), %0d results compared, reserved opcodes %0d",
             requests, directed, checked, per_op[OP_RSV6] + per_op[OP_RSV7]);
    $display("add %0d sub %0d mul %0d cmp %0d shl %0d shr %0d", per_op[smi_pkg::OP_ADD],
             per_op[smi_pkg::OP_SUB], per_op[smi_pkg::OP_MUL], per_op[smi_pkg::OP_CMP],
             per_op[smi_pkg::OP_SHL], per_op[smi_pkg::OP_SHR]);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[sign_magnitude_integer_alu_core.f]
+incdir+design
design/smi_pkg.sv
design/smi_exec.sv
design/smi_final.sv
design/sign_magnitude_integer_alu_core.sv
tb/alu_result_checker.sv
tb/tb.sv
